// ----- src/ezr_pkg.sv -----
// Package for the ZYX Euler angle to rotation basis block: widths, constants, helpers.
package ezr_pkg;

    localparam int ANG_W = 32;
    localparam int OUT_W = 16;
    localparam int Q_W   = 32;   // signed Q2.30 working width

    localparam logic [24:0] DEG_FULL    = 25'd23592960;
    localparam logic [22:0] DEG_QUARTER = 23'd5898240;
    localparam logic [21:0] DEG_EIGHTH  = 22'd2949120;
    localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
    localparam logic [31:0] Q30_ONE     = 32'd1073741824;

    // Whole degrees are reduced modulo 360 after a bias of 92 turns keeps them positive.
    localparam logic [16:0] DEG_BIAS = 17'd33120;
    localparam int          SH_360   = 26;
    localparam logic [17:0] RCP_360  = 18'(((64'd1 << SH_360) + 64'd359) / 64'd360);

    // Reciprocals for the Horner divisors; exact for dividends below 2^30.
    localparam int          SH_42  = 36;
    localparam int          SH_56  = 36;
    localparam int          SH_20  = 35;
    localparam int          SH_30  = 35;
    localparam int          SH_12  = 34;
    localparam int          SH_6   = 33;
    localparam logic [30:0] RCP_42 = 31'(((64'd1 << SH_42) + 64'd41) / 64'd42);
    localparam logic [30:0] RCP_56 = 31'(((64'd1 << SH_56) + 64'd55) / 64'd56);
    localparam logic [30:0] RCP_20 = 31'(((64'd1 << SH_20) + 64'd19) / 64'd20);
    localparam logic [30:0] RCP_30 = 31'(((64'd1 << SH_30) + 64'd29) / 64'd30);
    localparam logic [30:0] RCP_12 = 31'(((64'd1 << SH_12) + 64'd11) / 64'd12);
    localparam logic [30:0] RCP_6  = 31'(((64'd1 << SH_6) + 64'd5) / 64'd6);

    typedef struct packed {
        logic signed [ANG_W-1:0] yaw_deg;
        logic signed [ANG_W-1:0] pitch_deg;
        logic signed [ANG_W-1:0] roll_deg;
    } t_ang;

    typedef struct packed {
        logic signed [OUT_W-1:0] fwd_x;
        logic signed [OUT_W-1:0] fwd_y;
        logic signed [OUT_W-1:0] fwd_z;
        logic signed [OUT_W-1:0] left_x;
        logic signed [OUT_W-1:0] left_y;
        logic signed [OUT_W-1:0] left_z;
        logic signed [OUT_W-1:0] up_x;
        logic signed [OUT_W-1:0] up_y;
        logic signed [OUT_W-1:0] up_z;
    } t_bas;

    // Truncating division by a constant through its reciprocal.
    function automatic logic [31:0] div_rcp(input logic [31:0] x, input logic [30:0] m,
                                            input int s);
        logic [62:0] p;
        p = x * m;
        return 32'(p >> s);
    endfunction

    // Magnitude product of two Q2.30 values, truncated toward zero, sign applied.
    function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W-1:0] a,
                                                  input logic signed [Q_W-1:0] b);
        logic [Q_W-1:0] ma;
        logic [Q_W-1:0] mb;
        logic [2*Q_W-1:0] p;
        logic [Q_W-1:0] m;
        ma = a[Q_W-1] ? Q_W'(-a) : Q_W'(a);
        mb = b[Q_W-1] ? Q_W'(-b) : Q_W'(b);
        p  = ma * mb;
        m  = p[Q_W+29:30];
        return (a[Q_W-1] != b[Q_W-1]) ? -$signed(m) : $signed(m);
    endfunction

    // Round a Q2.30 value to Q1.15, half away from zero, with saturation.
    function automatic logic [OUT_W-1:0] to_q15(input logic signed [Q_W+1:0] v);
        logic [Q_W+1:0] m;
        logic [Q_W+1:0] r;
        m = v[Q_W+1] ? Q_W'(0) + (-v) : v;
        r = (m + (Q_W+2)'(16384)) >> 15;
        if (!v[Q_W+1] && r > (Q_W+2)'(32767)) r = (Q_W+2)'(32767);
        if (v[Q_W+1] && r > (Q_W+2)'(32768)) r = (Q_W+2)'(32768);
        return v[Q_W+1] ? OUT_W'(-r) : OUT_W'(r);
    endfunction

endpackage

// ----- src/ezr_if.sv -----
// Valid/ready stream interface carrying one payload beat.
interface ezr_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/ezr_sincos.sv -----
// Pipelined sine and cosine of a Q16.16 degree angle in Q2.30; fixed latency, shared stall.
module ezr_sincos (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [ezr_pkg::ANG_W-1:0]  i_ang,
    output logic signed [ezr_pkg::Q_W-1:0]    o_sin,
    output logic signed [ezr_pkg::Q_W-1:0]    o_cos
);
    localparam int LAT = 10;

    // stage 0: modulo reduction; the fraction bits pass, whole degrees go modulo 360
    logic [16:0] n_h;
    logic [34:0] n_hq;
    logic [8:0]  n_hdiv;
    logic [8:0]  n_deg;
    logic [24:0] r_r;
    always_comb begin
        n_h    = {i_ang[31], i_ang[31:16]} + ezr_pkg::DEG_BIAS;
        n_hq   = n_h * ezr_pkg::RCP_360;
        n_hdiv = n_hq[34:26];
        n_deg  = 9'(n_h - 17'(n_hdiv) * 17'd360);
    end
    always_ff @(posedge i_clk) if (i_en) r_r <= {n_deg, i_ang[15:0]};

    // stage 1: quadrant, fold
    logic [1:0] r_q [1:LAT];
    logic       r_sw [1:LAT];
    logic [22:0] r_t;
    logic [1:0]  n_q;
    logic [22:0] n_f;
    always_comb begin
        n_q = 2'd0;
        n_f = r_r[22:0];
        if (r_r >= 25'(3*ezr_pkg::DEG_QUARTER)) begin
            n_q = 2'd3; n_f = 23'(r_r - 25'(3*ezr_pkg::DEG_QUARTER));
        end else if (r_r >= 25'(2*ezr_pkg::DEG_QUARTER)) begin
            n_q = 2'd2; n_f = 23'(r_r - 25'(2*ezr_pkg::DEG_QUARTER));
        end else if (r_r >= 25'(ezr_pkg::DEG_QUARTER)) begin
            n_q = 2'd1; n_f = 23'(r_r - 25'(ezr_pkg::DEG_QUARTER));
        end
    end
    always_ff @(posedge i_clk) if (i_en) begin
        r_t     <= (n_f > 23'(ezr_pkg::DEG_EIGHTH)) ? ezr_pkg::DEG_QUARTER - n_f : n_f;
    end

    // stage 2: radians; stage 3: x squared
    logic [49:0] n_xp;
    logic [31:0] r_x [3:LAT-1];
    logic [31:0] r_x2;
    assign n_xp = r_t * ezr_pkg::DEG2RAD_Q32;
    logic [63:0] n_sq;
    assign n_sq = r_x[3] * r_x[3];
    logic [31:0] r_x2p [5:LAT];
    assign r_x2 = r_x2p[5];

    // Horner steps: stage k multiplies, stage k+1 divides and subtracts
    logic [31:0] r_a1, r_b1, r_a2, r_b2, r_a3, r_b3, r_b4, r_sin;
    logic [63:0] r_pa, r_pb;
    always_ff @(posedge i_clk) if (i_en) begin
        r_a1 <= ezr_pkg::Q30_ONE - ezr_pkg::div_rcp(r_x2, ezr_pkg::RCP_42, ezr_pkg::SH_42); // 4
        r_b1 <= ezr_pkg::Q30_ONE - ezr_pkg::div_rcp(r_x2, ezr_pkg::RCP_56, ezr_pkg::SH_56);
        r_pa <= r_x2p[6] * r_a1;                            // 5
        r_pb <= r_x2p[6] * r_b1;
        r_a2 <= ezr_pkg::Q30_ONE                            // 6
                - ezr_pkg::div_rcp(32'(r_pa[63:30]), ezr_pkg::RCP_20, ezr_pkg::SH_20);
        r_b2 <= ezr_pkg::Q30_ONE
                - ezr_pkg::div_rcp(32'(r_pb[63:30]), ezr_pkg::RCP_30, ezr_pkg::SH_30);
    end
    logic [63:0] r_pa2, r_pb2, r_pb3, r_ps;
    always_ff @(posedge i_clk) if (i_en) begin
        r_pa2 <= r_x2p[8] * r_a2;                               // 7
        r_pb2 <= r_x2p[8] * r_b2;
        r_a3  <= ezr_pkg::Q30_ONE                               // 8
                 - ezr_pkg::div_rcp(32'(r_pa2[63:30]), ezr_pkg::RCP_6, ezr_pkg::SH_6);
        r_b3  <= ezr_pkg::Q30_ONE
                 - ezr_pkg::div_rcp(32'(r_pb2[63:30]), ezr_pkg::RCP_12, ezr_pkg::SH_12);
        r_ps  <= r_x[9] * r_a3;                                 // 9
        r_pb3 <= r_x2p[10] * r_b3;
        r_sin <= r_ps[61:30];                                   // 10
        r_b4  <= ezr_pkg::Q30_ONE - (32'(r_pb3[63:30]) >> 1);
    end

    // delay lines for control and x
    always_ff @(posedge i_clk) if (i_en) begin
        r_q[1]   <= n_q;
        r_sw[1]  <= n_f > 23'(ezr_pkg::DEG_EIGHTH);
        r_x[3]   <= n_xp[49:18];
        r_x2p[5] <= n_sq[61:30];
        for (int k = 2; k <= LAT; k++) begin
            r_q[k]  <= r_q[k-1];
            r_sw[k] <= r_sw[k-1];
        end
        for (int k = 4; k <= LAT-1; k++) r_x[k] <= r_x[k-1];
        for (int k = 6; k <= LAT; k++) r_x2p[k] <= r_x2p[k-1];
    end

    logic signed [31:0] w_sf, w_cf;
    assign w_sf = r_sw[LAT] ? $signed(r_b4) : $signed(r_sin);
    assign w_cf = r_sw[LAT] ? $signed(r_sin) : $signed(r_b4);
    always_comb begin
        case (r_q[LAT])
            2'd0:    begin o_sin = w_sf;  o_cos = w_cf;  end
            2'd1:    begin o_sin = w_cf;  o_cos = -w_sf; end
            2'd2:    begin o_sin = -w_sf; o_cos = -w_cf; end
            default: begin o_sin = -w_cf; o_cos = w_sf;  end
        endcase
    end
endmodule

// ----- src/euler_zyx_to_rotation_basis.sv -----
// Top level: ZYX Euler angles to forward, left and up basis vectors in Q1.15.
// One angle triple enters per cycle and one basis leaves per cycle while the output
// is not stalled; each item passes through eleven register stages in the sine/cosine
// pipeline (modulo, fold, radians, square and seven Horner multiply/divide steps),
// then two stages of basis products and one of sum, round and saturate that loads
// the output register. The whole pipeline advances together on a single enable, so
// the output register may hold a beat while upstream stays put; nothing is lost or
// repeated. While a beat waits at the output with ready low, the input is held off.
module euler_zyx_to_rotation_basis (
    input logic  i_clk,
    input logic  i_rst_n,
    ezr_if.sink   i_ang,
    ezr_if.source o_bas
);
    localparam int DEPTH = 14;

    logic [DEPTH-1:0] r_vld;
    logic w_en;
    // advance when the output slot is empty or being drained
    assign w_en = !r_vld[DEPTH-1] || o_bas.ready;
    assign i_ang.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[DEPTH-2:0], i_ang.valid};
    end

    logic signed [31:0] w_sy, w_cy, w_sp, w_cp, w_sr, w_cr;
    ezr_sincos u_yaw (.i_clk(i_clk), .i_en(w_en), .i_ang(i_ang.data.yaw_deg),
                      .o_sin(w_sy), .o_cos(w_cy));
    ezr_sincos u_pit (.i_clk(i_clk), .i_en(w_en), .i_ang(i_ang.data.pitch_deg),
                      .o_sin(w_sp), .o_cos(w_cp));
    ezr_sincos u_rol (.i_clk(i_clk), .i_en(w_en), .i_ang(i_ang.data.roll_deg),
                      .o_sin(w_sr), .o_cos(w_cr));

    // stage A: pair products and captured sines and cosines
    logic signed [31:0] r_cycp, r_sycp, r_sp, r_cysp, r_sysp, r_cpsr, r_cpcr;
    logic signed [31:0] r_sy, r_cy, r_sr, r_cr;
    always_ff @(posedge i_clk) if (w_en) begin
        r_cycp <= ezr_pkg::qmul(w_cy, w_cp);
        r_sycp <= ezr_pkg::qmul(w_sy, w_cp);
        r_cysp <= ezr_pkg::qmul(w_cy, w_sp);
        r_sysp <= ezr_pkg::qmul(w_sy, w_sp);
        r_cpsr <= ezr_pkg::qmul(w_cp, w_sr);
        r_cpcr <= ezr_pkg::qmul(w_cp, w_cr);
        r_sp <= w_sp; r_sy <= w_sy; r_cy <= w_cy; r_sr <= w_sr; r_cr <= w_cr;
    end

    // stage B: second-level products
    logic signed [31:0] r_p [0:7];
    logic signed [31:0] r_b_cycp, r_b_sycp, r_b_sp, r_b_cpsr, r_b_cpcr;
    always_ff @(posedge i_clk) if (w_en) begin
        r_p[0] <= ezr_pkg::qmul(r_cysp, r_sr);
        r_p[1] <= ezr_pkg::qmul(r_sy, r_cr);
        r_p[2] <= ezr_pkg::qmul(r_sysp, r_sr);
        r_p[3] <= ezr_pkg::qmul(r_cy, r_cr);
        r_p[4] <= ezr_pkg::qmul(r_cysp, r_cr);
        r_p[5] <= ezr_pkg::qmul(r_sy, r_sr);
        r_p[6] <= ezr_pkg::qmul(r_sysp, r_cr);
        r_p[7] <= ezr_pkg::qmul(r_cy, r_sr);
        r_b_cycp <= r_cycp; r_b_sycp <= r_sycp; r_b_sp <= r_sp;
        r_b_cpsr <= r_cpsr; r_b_cpcr <= r_cpcr;
    end

    // stage C: sums, rounding, saturation into the output register
    function automatic logic signed [33:0] ext(input logic signed [31:0] v);
        return 34'(v);
    endfunction

    always_ff @(posedge i_clk) if (w_en) begin
        o_bas.data.fwd_x  <= ezr_pkg::to_q15(ext(r_b_cycp));
        o_bas.data.fwd_y  <= ezr_pkg::to_q15(ext(r_b_sycp));
        o_bas.data.fwd_z  <= ezr_pkg::to_q15(-ext(r_b_sp));
        o_bas.data.left_x <= ezr_pkg::to_q15(ext(r_p[0]) - ext(r_p[1]));
        o_bas.data.left_y <= ezr_pkg::to_q15(ext(r_p[2]) + ext(r_p[3]));
        o_bas.data.left_z <= ezr_pkg::to_q15(ext(r_b_cpsr));
        o_bas.data.up_x   <= ezr_pkg::to_q15(ext(r_p[4]) + ext(r_p[5]));
        o_bas.data.up_y   <= ezr_pkg::to_q15(ext(r_p[6]) - ext(r_p[7]));
        o_bas.data.up_z   <= ezr_pkg::to_q15(ext(r_b_cpcr));
    end

    assign o_bas.valid = r_vld[DEPTH-1];
endmodule

// ----- verif/tb_euler_zyx_to_rotation_basis.sv -----
// Self-checking testbench for the ZYX Euler angle to rotation basis block.
module tb_euler_zyx_to_rotation_basis;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ANG_W       = ezr_pkg::ANG_W;
    localparam int          OUT_W       = ezr_pkg::OUT_W;
    localparam logic [24:0] DEG_FULL    = ezr_pkg::DEG_FULL;
    localparam logic [22:0] DEG_QUARTER = ezr_pkg::DEG_QUARTER;
    localparam logic [21:0] DEG_EIGHTH  = ezr_pkg::DEG_EIGHTH;
    localparam logic [26:0] DEG2RAD_Q32 = ezr_pkg::DEG2RAD_Q32;

    localparam int  N_RANDOM   = 680;
    localparam int  CALM_TAIL  = 80;     // last beats sent and taken with no idling
    localparam int  HOLD_LEN   = 300;    // long receiver hold-off
    localparam int  HOLD_AT    = 200;    // result count at which the hold-off starts
    localparam int  DRAIN_CYC  = 40;     // settling wait after the last result beat
    localparam int  WDOG_LIMIT = 3000;

    logic i_clk;
    logic i_rst_n;

    ezr_if #(.t_payload(ezr_pkg::t_ang)) ang_bus ();
    ezr_if #(.t_payload(ezr_pkg::t_bas)) bas_bus ();

    euler_zyx_to_rotation_basis uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ang   (ang_bus),
        .o_bas   (bas_bus)
    );

    // Period 12 ns.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------
    // Predictor: fixed-point sine/cosine and basis products.
    // ------------------------------------------------------------------
    localparam longint ONE_Q30 = 64'd1073741824;

    function automatic longint unsigned deg_to_rad(input longint unsigned t);
        return (t * longint'(DEG2RAD_Q32)) >> 18;
    endfunction

    function automatic longint unsigned taylor_sin(input longint unsigned x);
        longint unsigned x2;
        longint unsigned a;
        x2 = (x * x) >> 30;
        a  = ONE_Q30 - x2 / 42;
        a  = ONE_Q30 - ((x2 * a) >> 30) / 20;
        a  = ONE_Q30 - ((x2 * a) >> 30) / 6;
        return (x * a) >> 30;
    endfunction

    function automatic longint unsigned taylor_cos(input longint unsigned x);
        longint unsigned x2;
        longint unsigned b;
        x2 = (x * x) >> 30;
        b  = ONE_Q30 - x2 / 56;
        b  = ONE_Q30 - ((x2 * b) >> 30) / 30;
        b  = ONE_Q30 - ((x2 * b) >> 30) / 12;
        b  = ONE_Q30 - ((x2 * b) >> 30) / 2;
        return b;
    endfunction

    // Reduce modulo 360 degrees, fold into the first octant, map the quadrant.
    function automatic void angle_sincos(input logic signed [ANG_W-1:0] ang,
                                         output longint s, output longint c);
        longint r;
        longint q;
        longint f;
        longint sf;
        longint cf;
        r = longint'(ang) % longint'(DEG_FULL);
        if (r < 0) r += longint'(DEG_FULL);
        q = r / longint'(DEG_QUARTER);
        f = r - q * longint'(DEG_QUARTER);
        if (f <= longint'(DEG_EIGHTH)) begin
            sf = longint'(taylor_sin(deg_to_rad(f)));
            cf = longint'(taylor_cos(deg_to_rad(f)));
        end else begin
            sf = longint'(taylor_cos(deg_to_rad(longint'(DEG_QUARTER) - f)));
            cf = longint'(taylor_sin(deg_to_rad(longint'(DEG_QUARTER) - f)));
        end
        case (q & 3)
            0: begin s = sf;  c = cf;  end
            1: begin s = cf;  c = -sf; end
            2: begin s = -sf; c = -cf; end
            default: begin s = -cf; c = sf; end
        endcase
    endfunction

    // Magnitude product truncated toward zero, sign applied afterwards.
    function automatic longint q30_mul(input longint a, input longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m  = (ma * mb) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    // Round half away from zero to Q1.15, then saturate.
    function automatic logic [OUT_W-1:0] round_q15(input longint v);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        m = (m + 16384) >> 15;
        if (v >= 0 && m > 32767) m = 32767;
        if (v < 0 && m > 32768) m = 32768;
        return (v < 0) ? OUT_W'(-longint'(m)) : OUT_W'(m);
    endfunction

    function automatic ezr_pkg::t_bas rotation_basis(input ezr_pkg::t_ang a);
        longint sy, cy, sp, cp, sr, cr, cysp, sysp;
        ezr_pkg::t_bas b;
        angle_sincos(a.yaw_deg, sy, cy);
        angle_sincos(a.pitch_deg, sp, cp);
        angle_sincos(a.roll_deg, sr, cr);
        cysp     = q30_mul(cy, sp);
        sysp     = q30_mul(sy, sp);
        b.fwd_x  = round_q15(q30_mul(cy, cp));
        b.fwd_y  = round_q15(q30_mul(sy, cp));
        b.fwd_z  = round_q15(-sp);
        b.left_x = round_q15(q30_mul(cysp, sr) - q30_mul(sy, cr));
        b.left_y = round_q15(q30_mul(sysp, sr) + q30_mul(cy, cr));
        b.left_z = round_q15(q30_mul(cp, sr));
        b.up_x   = round_q15(q30_mul(cysp, cr) + q30_mul(sy, sr));
        b.up_y   = round_q15(q30_mul(sysp, cr) - q30_mul(cy, sr));
        b.up_z   = round_q15(q30_mul(cp, cr));
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus and bookkeeping.
    // ------------------------------------------------------------------
    ezr_pkg::t_ang pending_angles[$];
    ezr_pkg::t_bas expected_bases[$];
    int   n_errors    = 0;
    int   n_taken_in  = 0;
    int   n_taken_out = 0;
    int   n_total_in  = 0;
    bit   ang_took    = 1'b0;   // set at the rising edge when an input beat is taken
    bit   hold_done   = 1'b0;
    int   hold_cnt    = 0;
    int   src_idle    = 0;
    int   snk_idle    = 0;
    int   quiet_cyc   = 0;

    string field_name[9] = '{"fwd_x", "fwd_y", "fwd_z", "left_x", "left_y", "left_z",
                             "up_x", "up_y", "up_z"};

    function automatic logic signed [ANG_W-1:0] pick_angle();
        logic signed [ANG_W-1:0] v;
        case ($urandom_range(0, 3)) inside
            0, 1: v = $urandom;
            // near a multiple of 45 degrees, where the fold and quadrant change
            2: v = ANG_W'(longint'($urandom_range(0, 16)) * longint'(DEG_EIGHTH) - 8
                          + longint'($urandom_range(0, 16)))
                   * (($urandom_range(0, 1) != 0) ? -1 : 1);
            default: v = ANG_W'($signed($urandom_range(0, 47185920))) - ANG_W'(23592960);
        endcase
        return v;
    endfunction

    task automatic add_angles(input logic signed [ANG_W-1:0] y,
                              input logic signed [ANG_W-1:0] p,
                              input logic signed [ANG_W-1:0] r);
        ezr_pkg::t_ang a;
        a.yaw_deg   = y;
        a.pitch_deg = p;
        a.roll_deg  = r;
        pending_angles.push_back(a);
    endtask

    // Driver: hold valid until the beat is taken, idle in random bursts.
    always @(negedge i_clk) begin
        bit nxt_valid;
        ezr_pkg::t_ang nxt_data;
        nxt_valid = ang_bus.valid;
        nxt_data  = ang_bus.data;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (ang_took) begin
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (src_idle > 0) begin
                    src_idle--;
                end else if (pending_angles.size() > 0) begin
                    if (pending_angles.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
                        src_idle = $urandom_range(0, 8);
                    end else begin
                        nxt_data  = pending_angles.pop_front();
                        nxt_valid = 1'b1;
                    end
                end
            end
        end
        ang_bus.valid <= nxt_valid;
        ang_bus.data  <= nxt_data;
    end

    // Receiver: random stalls, one long hold-off so that the pipeline fills up.
    always @(negedge i_clk) begin
        bit nxt_ready;
        nxt_ready = 1'b1;
        if (!i_rst_n) begin
            nxt_ready = 1'b0;
        end else if (!hold_done && n_taken_out >= HOLD_AT) begin
            nxt_ready = 1'b0;
            hold_cnt++;
            if (hold_cnt >= HOLD_LEN) hold_done = 1'b1;
        end else if (snk_idle > 0) begin
            nxt_ready = 1'b0;
            snk_idle--;
        end else if (n_total_in - n_taken_out > CALM_TAIL && $urandom_range(0, 5) == 0) begin
            nxt_ready = 1'b0;
            snk_idle  = $urandom_range(0, 8);
        end
        bas_bus.ready <= nxt_ready;
    end

    // Monitor: predict on each input beat, check each output beat.
    always @(posedge i_clk) begin
        ezr_pkg::t_bas exp_b;
        logic [9*OUT_W-1:0] e_bits;
        logic [9*OUT_W-1:0] a_bits;
        ang_took = 1'b0;
        if (i_rst_n) begin
            if (ang_bus.valid && ang_bus.ready) begin
                ang_took = 1'b1;
                n_taken_in++;
                expected_bases.push_back(rotation_basis(ang_bus.data));
            end
            if (bas_bus.valid && bas_bus.ready) begin
                n_taken_out++;
                if (expected_bases.size() == 0) begin
                    $display("%0t: unexpected basis beat, expected none, actual %h", $time,
                             bas_bus.data);
                    n_errors++;
                end else begin
                    exp_b  = expected_bases.pop_front();
                    e_bits = exp_b;
                    a_bits = bas_bus.data;
                    for (int i = 0; i < 9; i++) begin
                        if (e_bits[(8-i)*OUT_W +: OUT_W] !== a_bits[(8-i)*OUT_W +: OUT_W]) begin
                            $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                                     field_name[i],
                                     $signed(e_bits[(8-i)*OUT_W +: OUT_W]),
                                     $signed(a_bits[(8-i)*OUT_W +: OUT_W]));
                            n_errors++;
                        end
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (ang_bus.valid && ang_bus.ready) || (bas_bus.valid && bas_bus.ready)) begin
            quiet_cyc <= 0;
        end else begin
            quiet_cyc <= quiet_cyc + 1;
            if (quiet_cyc >= WDOG_LIMIT) begin
                $display("tb_euler_zyx_to_rotation_basis: FAIL");
                $finish;
            end
        end
    end

    initial begin
        ang_bus.valid = 1'b0;
        ang_bus.data  = '0;
        bas_bus.ready = 1'b0;
        i_rst_n       = 1'b0;

        // Directed: zero, range extremes, quadrant and octant boundaries.
        add_angles(32'sd0, 32'sd0, 32'sd0);
        add_angles(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        add_angles(32'sh80000000, 32'sh80000000, 32'sh80000000);
        add_angles(32'sh7fffffff, 32'sh80000000, 32'sd0);
        add_angles(32'sd5898240, 32'sd0, 32'sd0);          // yaw 90
        add_angles(32'sd0, 32'sd5898240, 32'sd0);          // pitch 90
        add_angles(32'sd0, -32'sd5898240, 32'sd0);         // pitch -90
        add_angles(32'sd0, 32'sd0, 32'sd5898240);          // roll 90
        add_angles(32'sd2949120, 32'sd2949120, 32'sd2949120);   // exactly 45
        add_angles(32'sd2949121, 32'sd2949119, 32'sd2949121);   // either side of 45
        add_angles(32'sd11796480, 32'sd11796480, 32'sd11796480); // 180
        add_angles(32'sd17694720, 32'sd17694720, 32'sd17694720); // 270
        add_angles(32'sd23592960, -32'sd23592960, 32'sd23592959); // 360
        add_angles(-32'sd1, 32'sd1, -32'sd1);
        add_angles(32'sd1966080, 32'sd3932160, -32'sd1966080);  // 30, 60, -30
        add_angles(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f);
        add_angles(32'shaaaaaaaa, 32'sh55555555, 32'shf0f0f0f0);
        add_angles(-32'sd8847360, 32'sd20643840, -32'sd14745600); // -135, 315, -225

        for (int i = 0; i < N_RANDOM; i++) begin
            add_angles(pick_angle(), pick_angle(), pick_angle());
        end
        n_total_in = pending_angles.size();

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (n_taken_in == n_total_in);
        wait (n_taken_out == n_total_in);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (n_errors == 0 && expected_bases.size() == 0) begin
            $display("tb_euler_zyx_to_rotation_basis: PASS");
        end else begin
            $display("tb_euler_zyx_to_rotation_basis: FAIL");
        end
        $finish;
    end

endmodule
